/* design/rles_pkg.sv */
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, request codes and duty scaling for the RGB LED effect
// sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

    // pwm duty resolution and breathe ramp length (steps = 2**shift)
    localparam int DUTY_BITS     = 10;
    localparam int BREATHE_SHIFT = 7;
    localparam int BREATHE_STEPS = 1 << BREATHE_SHIFT;
    // a breathe level is held period / (2 * steps) ticks
    localparam int HOLD_SHIFT    = BREATHE_SHIFT + 1;

    // color channels and fade quotient size (fade delta never exceeds 8 bits)
    localparam int N_CH      = 3;
    localparam int CH_W      = 2;
    localparam int QUO_BITS  = 8;
    localparam int QCNT_W    = 3;
    localparam int PROD_W    = 24;

    // duty scaling constants: duty = c * DUTY_MAX / 255
    localparam int DUTY_MAX  = (1 << DUTY_BITS) - 1;
    localparam int SCALE_INT = DUTY_MAX / 255;
    localparam int SCALE_REM = DUTY_MAX % 255;

    // request type codes
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_SET     = 3'd1;
    localparam logic [2:0] REQ_FADE    = 3'd2;
    localparam logic [2:0] REQ_BLINK   = 3'd3;
    localparam logic [2:0] REQ_BREATHE = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        save_color;
        logic [15:0] time_length;
        logic [15:0] repeat_count;
    } t_in_req;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_red;
        logic [DUTY_BITS-1:0] duty_green;
        logic [DUTY_BITS-1:0] duty_blue;
        logic                 busy_res;
        logic                 rejected;
    } t_out_res;

    // c * DUTY_MAX / 255, truncated; the fractional part uses x/255 by
    // reciprocal multiply (x * 257 >> 16) plus one correction step
    function automatic logic [DUTY_BITS-1:0] duty_scale(input logic [7:0] c);
        logic [15:0] x;
        logic [23:0] prod;
        logic [7:0]  q0;
        logic [15:0] rem;
        logic [31:0] total;
        x     = 16'(SCALE_REM * int'(c));
        prod  = {x, 8'd0} + 24'(x);
        q0    = prod[23:16];
        rem   = x - 16'(q0) * 16'd255;
        total = 32'(SCALE_INT * int'(c)) + 32'(q0) + 32'(rem >= 16'd255);
        return total[DUTY_BITS-1:0];
    endfunction

endpackage

/* design/rgb_led_effect_sequencer.sv */
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer
// Tick-driven RGB LED effect sequencer: set color, linear fade, blink and
// breathe, with one PWM duty triple reported per request.
// ----------------------------------------------------------------------------
// Every request (a one-millisecond tick or a command) produces one result with
// the three duties now shown, the busy flag and the reject flag. Commands that
// arrive while an effect runs are rejected and change nothing. Requests are
// taken one at a time: a request that needs no arithmetic goes straight to the
// output stage, while a breathe tick that changes the level runs one multiply
// per channel and a fade step runs one multiply and an 8-step division per
// channel, all on the single shared multiplier and compare-subtract divider,
// which serve the three color channels in turn. A finished result waits in the
// output register while the next request is already accepted.
module rgb_led_effect_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rles_pkg::t_in_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rles_pkg::t_out_res o_out_res
);
    import rles_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FADE    = 3'd2,
        MODE_BLINK   = 3'd3,
        MODE_BREATHE = 3'd4
    } t_mode;

    t_state            r_state;
    t_mode             r_mode;
    logic [7:0]        r_saved  [N_CH];
    logic [7:0]        r_start  [N_CH];
    logic [7:0]        r_target [N_CH];
    logic [7:0]        r_shown  [N_CH];
    logic [15:0]       r_step;
    logic [15:0]       r_hold;
    logic [15:0]       r_cycles;
    logic              r_ramp;
    logic [15:0]       r_len;
    logic              r_rej;
    logic              r_calc_fade;
    logic [CH_W-1:0]   r_ch;
    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_dvs;
    logic [QUO_BITS-1:0] r_quo;
    logic              r_neg;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_out_valid;
    t_out_res          r_out_res;

    logic [7:0]        in_col [N_CH];
    logic [16:0]       hold_inc;
    logic [15:0]       breathe_hold;
    logic [8:0]        diff;
    logic [8:0]        diff_abs;
    logic [7:0]        mul_a;
    logic [PROD_W-1:0] mul_p;
    logic              div_ge;
    logic [PROD_W-1:0] div_sub;
    logic [7:0]        fade_val;
    logic [15:0]       cycles_dec;

    // request color as an array
    assign in_col[0] = i_in_req.red;
    assign in_col[1] = i_in_req.green;
    assign in_col[2] = i_in_req.blue;

    // tick bookkeeping
    assign hold_inc     = {1'b0, r_hold} + 17'd1;
    assign breathe_hold = r_len >> HOLD_SHIFT;
    assign cycles_dec   = r_cycles - 16'd1;

    // shared multiplier: |target - start| * step for fade, saved * level for breathe
    assign diff     = {1'b0, r_target[r_ch]} - {1'b0, r_start[r_ch]};
    assign diff_abs = diff[8] ? (9'd0 - diff) : diff;
    assign mul_a    = r_calc_fade ? diff_abs[7:0] : r_saved[r_ch];
    assign mul_p    = {8'd0, r_step} * {16'd0, mul_a};

    // shared compare-subtract divider step
    assign div_ge  = (r_rem >= r_dvs);
    assign div_sub = r_rem - r_dvs;

    // fade value, truncated toward zero
    assign fade_val = r_neg ? (r_start[r_ch] - r_quo) : (r_start[r_ch] + r_quo);

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // sequencer, effect state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_saved     <= '{default: 8'd0};
            r_start     <= '{default: 8'd0};
            r_target    <= '{default: 8'd0};
            r_shown     <= '{default: 8'd0};
            r_step      <= '0;
            r_hold      <= '0;
            r_cycles    <= '0;
            r_ramp      <= 1'b0;
            r_len       <= '0;
            r_rej       <= 1'b0;
            r_calc_fade <= 1'b0;
            r_ch        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_rej   <= 1'b0;
                        r_ch    <= '0;
                        r_state <= S_DONE;
                        case (i_in_req.req_type)
                            // advance the running effect
                            REQ_TICK: begin
                                case (r_mode)
                                    MODE_FADE: begin
                                        if (r_step >= r_len) begin
                                            r_saved <= r_target;
                                            r_shown <= r_target;
                                            r_mode  <= MODE_IDLE;
                                        end else begin
                                            r_step      <= r_step + 16'd1;
                                            r_calc_fade <= 1'b1;
                                            r_state     <= S_MUL;
                                        end
                                    end
                                    MODE_BLINK: begin
                                        if (hold_inc < {1'b0, r_len}) begin
                                            r_hold <= hold_inc[15:0];
                                        end else begin
                                            r_hold <= '0;
                                            if (!r_ramp) begin
                                                r_ramp  <= 1'b1;
                                                r_shown <= r_saved;
                                            end else begin
                                                r_cycles <= cycles_dec;
                                                if (cycles_dec == 16'd0) begin
                                                    r_mode <= MODE_IDLE;
                                                end else begin
                                                    r_ramp  <= 1'b0;
                                                    r_shown <= '{default: 8'd0};
                                                end
                                            end
                                        end
                                    end
                                    MODE_BREATHE: begin
                                        if (hold_inc < {1'b0, breathe_hold}) begin
                                            r_hold <= hold_inc[15:0];
                                        end else begin
                                            r_hold      <= '0;
                                            r_calc_fade <= 1'b0;
                                            r_state     <= S_MUL;
                                            if (!r_ramp) begin
                                                if (r_step < 16'(BREATHE_STEPS)) begin
                                                    r_step <= r_step + 16'd1;
                                                end else begin
                                                    r_ramp <= 1'b1;
                                                end
                                            end else if (r_step != 16'd0) begin
                                                r_step <= r_step - 16'd1;
                                            end else begin
                                                r_cycles <= cycles_dec;
                                                if (cycles_dec == 16'd0) begin
                                                    r_shown <= r_saved;
                                                    r_mode  <= MODE_IDLE;
                                                    r_state <= S_DONE;
                                                end else begin
                                                    r_ramp <= 1'b0;
                                                end
                                            end
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            // commands
                            REQ_SET, REQ_FADE, REQ_BLINK, REQ_BREATHE: begin
                                if (r_mode != MODE_IDLE) begin
                                    r_rej <= 1'b1;
                                end else begin
                                    case (i_in_req.req_type)
                                        REQ_SET: begin
                                            r_shown <= in_col;
                                            if (i_in_req.save_color) begin
                                                r_saved <= in_col;
                                            end
                                        end
                                        REQ_FADE: begin
                                            r_target <= in_col;
                                            if (i_in_req.time_length == 16'd0) begin
                                                r_saved <= in_col;
                                                r_shown <= in_col;
                                            end else begin
                                                // step zero shows the start color
                                                r_start <= r_saved;
                                                r_shown <= r_saved;
                                                r_len   <= i_in_req.time_length;
                                                r_step  <= '0;
                                                r_mode  <= MODE_FADE;
                                            end
                                        end
                                        REQ_BLINK: begin
                                            if (i_in_req.repeat_count != 16'd0) begin
                                                if (i_in_req.time_length == 16'd0) begin
                                                    r_shown <= r_saved;
                                                end else begin
                                                    r_len    <= i_in_req.time_length;
                                                    r_cycles <= i_in_req.repeat_count;
                                                    r_hold   <= '0;
                                                    r_ramp   <= 1'b0;
                                                    r_mode   <= MODE_BLINK;
                                                    r_shown  <= '{default: 8'd0};
                                                end
                                            end
                                        end
                                        default: begin
                                            // breathe
                                            r_len <= i_in_req.time_length;
                                            if (i_in_req.repeat_count == 16'd0 ||
                                                (i_in_req.time_length >> HOLD_SHIFT) == 16'd0)
                                            begin
                                                r_shown <= r_saved;
                                            end else begin
                                                r_cycles <= i_in_req.repeat_count;
                                                r_hold   <= '0;
                                                r_ramp   <= 1'b0;
                                                r_step   <= '0;
                                                r_mode   <= MODE_BREATHE;
                                                r_shown  <= '{default: 8'd0};
                                            end
                                        end
                                    endcase
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // product of the current channel
                S_MUL: begin
                    r_rem   <= mul_p;
                    r_dvs   <= PROD_W'({8'd0, r_len}) << (QUO_BITS - 1);
                    r_neg   <= diff[8];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= r_calc_fade ? S_DIV : S_WB;
                end

                // one quotient bit per cycle
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_sub;
                    end
                    r_quo <= {r_quo[QUO_BITS-2:0], div_ge};
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == QCNT_W'(QUO_BITS - 1)) begin
                        r_state <= S_WB;
                    end
                end

                // write back channel color, move to next channel
                S_WB: begin
                    r_shown[r_ch] <= r_calc_fade ? fade_val : r_rem[BREATHE_SHIFT +: 8];
                    if (r_ch == CH_W'(N_CH - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_MUL;
                    end
                end

                // hand result to the output register
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid          <= 1'b1;
                        r_out_res.duty_red   <= duty_scale(r_shown[0]);
                        r_out_res.duty_green <= duty_scale(r_shown[1]);
                        r_out_res.duty_blue  <= duty_scale(r_shown[2]);
                        r_out_res.busy_res   <= (r_mode != MODE_IDLE);
                        r_out_res.rejected   <= r_rej;
                        r_state              <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* test/tb_rgb_led_effect_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_rgb_led_effect_sequencer
// Self-checking bench for the LED effect sequencer. A directed opener hits the
// degenerate commands and field extremes. A random run then issues mostly
// commands while the effect engine is idle and ticks while it is busy, with
// some rejected commands and unused codes mixed in. Every result is checked
// field by field against an in-bench model of the effect state machine.
// ----------------------------------------------------------------------------
module tb_rgb_led_effect_sequencer;
    import rles_pkg::*;

    localparam int          RANDOM_ITEMS      = 1300;
    localparam int          PAUSE_AT          = 700;
    localparam int          LONG_HOLD_AT      = 400;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES      = 80;
    localparam int          MAX_WAIT          = 17;
    localparam int          MAX_BREATHE_RUNS  = 1;
    localparam int          MAX_PRINTED       = 20;
    localparam int          COLOR_MAX         = 255;
    localparam logic [2:0]  REQ_UNUSED_FIRST  = 3'd5;
    localparam logic [2:0]  REQ_UNUSED_LAST   = 3'd7;

    typedef enum logic [2:0] {
        FX_IDLE    = 3'd0,
        FX_FADE    = 3'd2,
        FX_BLINK   = 3'd3,
        FX_BREATHE = 3'd4
    } t_fx_mode;

    // effect state model plus the queue of duty triples still to come out
    class effect_scoreboard;
        logic [7:0]           saved_c[3];
        logic [7:0]           start_c[3];
        logic [7:0]           target_c[3];
        t_fx_mode             mode;
        int unsigned          step_idx;
        int unsigned          hold_cnt;
        int unsigned          cycles_left;
        int unsigned          fx_len;
        bit                   ramp_down;
        logic [DUTY_BITS-1:0] duty[3];
        t_out_res             duty_q[$];
        int unsigned          n_mismatch;
        int unsigned          n_checked;
        int unsigned          n_rejected;
        int unsigned          n_unused;
        int unsigned          n_cmd[8];

        function new();
            int k;
            for (k = 0; k < 3; k++) begin
                saved_c[k]  = '0;
                start_c[k]  = '0;
                target_c[k] = '0;
                duty[k]     = '0;
            end
            for (k = 0; k < 8; k++) n_cmd[k] = 0;
            mode        = FX_IDLE;
            step_idx    = 0;
            hold_cnt    = 0;
            cycles_left = 0;
            fx_len      = 0;
            ramp_down   = 0;
            n_mismatch  = 0;
            n_checked   = 0;
            n_rejected  = 0;
            n_unused    = 0;
        endfunction

        function bit is_busy();
            return mode != FX_IDLE;
        endfunction

        function int unsigned pending();
            return duty_q.size();
        endfunction

        // 8-bit color to pwm duty, truncated
        function logic [DUTY_BITS-1:0] to_duty(int unsigned c);
            int unsigned prod;
            prod = (c & COLOR_MAX) * DUTY_MAX / COLOR_MAX;
            return DUTY_BITS'(prod);
        endfunction

        function void show_rgb(int unsigned r, int unsigned g, int unsigned b);
            duty[0] = to_duty(r);
            duty[1] = to_duty(g);
            duty[2] = to_duty(b);
        endfunction

        function void show_saved();
            show_rgb(saved_c[0], saved_c[1], saved_c[2]);
        endfunction

        // linear interpolation, signed division truncates toward zero
        function void show_fade();
            int unsigned v[3];
            int          s;
            int          d;
            int          k;
            for (k = 0; k < 3; k++) begin
                s    = int'(start_c[k]);
                d    = int'(target_c[k]) - s;
                v[k] = s + (d * int'(step_idx)) / int'(fx_len);
            end
            show_rgb(v[0], v[1], v[2]);
        endfunction

        function void show_breathe();
            int unsigned v[3];
            int          k;
            for (k = 0; k < 3; k++) v[k] = saved_c[k] * step_idx / BREATHE_STEPS;
            show_rgb(v[0], v[1], v[2]);
        endfunction

        function int unsigned breathe_hold();
            return fx_len / (2 * BREATHE_STEPS);
        endfunction

        // one tick of the running effect
        function void step_effect();
            case (mode)
                FX_FADE: begin
                    if (step_idx >= fx_len) begin
                        saved_c = target_c;
                        show_saved();
                        mode = FX_IDLE;
                    end else begin
                        step_idx++;
                        show_fade();
                    end
                end
                FX_BLINK: begin
                    hold_cnt++;
                    if (hold_cnt >= fx_len) begin
                        hold_cnt = 0;
                        if (!ramp_down) begin
                            ramp_down = 1;
                            show_saved();
                        end else begin
                            cycles_left = (cycles_left - 1) & 16'hFFFF;
                            if (cycles_left == 0) begin
                                mode = FX_IDLE;
                            end else begin
                                ramp_down = 0;
                                show_rgb(0, 0, 0);
                            end
                        end
                    end
                end
                FX_BREATHE: begin
                    hold_cnt++;
                    if (hold_cnt >= breathe_hold()) begin
                        hold_cnt = 0;
                        if (!ramp_down) begin
                            if (step_idx < BREATHE_STEPS) step_idx++;
                            else ramp_down = 1;
                            show_breathe();
                        end else if (step_idx > 0) begin
                            step_idx--;
                            show_breathe();
                        end else begin
                            cycles_left = (cycles_left - 1) & 16'hFFFF;
                            if (cycles_left == 0) begin
                                show_saved();
                                mode = FX_IDLE;
                            end else begin
                                ramp_down = 0;
                                show_breathe();
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // apply an accepted request and queue the duty triple it yields
        function void note_request(t_in_req r);
            t_out_res want;
            bit       rej;
            rej = 0;
            if (r.req_type > REQ_BREATHE) n_unused++;
            else n_cmd[r.req_type]++;
            if (r.req_type == REQ_TICK) begin
                step_effect();
            end else if (r.req_type <= REQ_BREATHE) begin
                if (mode != FX_IDLE) begin
                    rej = 1;
                end else begin
                    case (r.req_type)
                        REQ_SET: begin
                            show_rgb(r.red, r.green, r.blue);
                            if (r.save_color) saved_c = '{r.red, r.green, r.blue};
                        end
                        REQ_FADE: begin
                            target_c = '{r.red, r.green, r.blue};
                            if (r.time_length == 0) begin
                                saved_c = target_c;
                                show_saved();
                            end else begin
                                start_c  = saved_c;
                                fx_len   = r.time_length;
                                step_idx = 0;
                                mode     = FX_FADE;
                                show_fade();
                            end
                        end
                        REQ_BLINK: begin
                            if (r.repeat_count != 0) begin
                                if (r.time_length == 0) begin
                                    show_saved();
                                end else begin
                                    fx_len      = r.time_length;
                                    cycles_left = r.repeat_count;
                                    hold_cnt    = 0;
                                    ramp_down   = 0;
                                    mode        = FX_BLINK;
                                    show_rgb(0, 0, 0);
                                end
                            end
                        end
                        default: begin
                            fx_len = r.time_length;
                            if (r.repeat_count == 0 || breathe_hold() == 0) begin
                                show_saved();
                            end else begin
                                cycles_left = r.repeat_count;
                                hold_cnt    = 0;
                                ramp_down   = 0;
                                step_idx    = 0;
                                mode        = FX_BREATHE;
                                show_breathe();
                            end
                        end
                    endcase
                end
            end
            if (rej) n_rejected++;
            want.duty_red   = duty[0];
            want.duty_green = duty[1];
            want.duty_blue  = duty[2];
            want.busy_res   = (mode != FX_IDLE);
            want.rejected   = rej;
            duty_q.push_back(want);
        endfunction

        task report(string what, int unsigned got_v, int unsigned want_v);
            n_mismatch++;
            if (n_mismatch <= MAX_PRINTED)
                $display("mismatch at %0t, result %0d: %s got %0d want %0d",
                         $time, n_checked, what, got_v, want_v);
        endtask

        task check_result(t_out_res got);
            t_out_res want;
            if (duty_q.size() == 0) begin
                report("result with nothing pending", 1, 0);
                return;
            end
            want = duty_q.pop_front();
            n_checked++;
            if (got.duty_red !== want.duty_red)
                report("duty_red", got.duty_red, want.duty_red);
            if (got.duty_green !== want.duty_green)
                report("duty_green", got.duty_green, want.duty_green);
            if (got.duty_blue !== want.duty_blue)
                report("duty_blue", got.duty_blue, want.duty_blue);
            if (got.busy_res !== want.busy_res)
                report("busy_res", got.busy_res, want.busy_res);
            if (got.rejected !== want.rejected)
                report("rejected", got.rejected, want.rejected);
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_out_stall = 1'b0;
    t_in_req           i_in_req    = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_res          o_out_res;
    effect_scoreboard  led_sb;
    bit                src_quiet   = 1'b0;

    rgb_led_effect_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // 10 unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_req make_request(logic [2:0] kind, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] b,
                                             logic save, logic [15:0] len,
                                             logic [15:0] reps);
        t_in_req q;
        q.req_type     = kind;
        q.red          = r;
        q.green        = g;
        q.blue         = b;
        q.save_color   = save;
        q.time_length  = len;
        q.repeat_count = reps;
        return q;
    endfunction

    function automatic t_in_req random_fields();
        t_in_req q;
        q.req_type     = REQ_TICK;
        q.red          = 8'($urandom);
        q.green        = 8'($urandom);
        q.blue         = 8'($urandom);
        q.save_color   = 1'($urandom);
        q.time_length  = 16'($urandom);
        q.repeat_count = 16'($urandom);
        return q;
    endfunction

    // offer one request after a random gap, hold it until taken
    task automatic send_request(input t_in_req r);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        led_sb.note_request(r);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (led_sb.pending() != 0);
    endtask

    // degenerate commands and field extremes
    task automatic run_directed();
        send_request(make_request(REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
        send_request(make_request(REQ_SET, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'h0000, 16'h0000));
        send_request(make_request(REQ_SET, 8'hFF, 8'h01, 8'h80, 1'b1, 16'hFFFF, 16'hFFFF));
        // zero-length fade saves target at once
        send_request(make_request(REQ_FADE, 8'h0A, 8'hC8, 8'h00, 1'b0, 16'h0000, 16'h0000));
        // short fade with falling and rising channels
        send_request(make_request(REQ_FADE, 8'h00, 8'hFF, 8'h03, 1'b0, 16'd3, 16'h0000));
        send_request(make_request(REQ_BLINK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
        repeat (4)
            send_request(make_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000));
        // blink with no repeats, then with zero interval
        send_request(make_request(REQ_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF, 16'h0000));
        send_request(make_request(REQ_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 16'hFFFF));
        send_request(make_request(REQ_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 16'd1, 16'd1));
        repeat (2)
            send_request(make_request(REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
        // breathe with no repeats, then with too short a period
        send_request(make_request(REQ_BREATHE, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF, 16'h0000));
        send_request(make_request(REQ_BREATHE, 8'h00, 8'h00, 8'h00, 1'b0, 16'd255, 16'hFFFF));
        // unused request codes
        send_request(make_request(REQ_UNUSED_FIRST, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                  16'hFFFF, 16'hFFFF));
        send_request(make_request(3'(REQ_UNUSED_FIRST + 1), 8'h55, 8'hAA, 8'h55, 1'b0,
                                  16'hAAAA, 16'h5555));
        send_request(make_request(REQ_UNUSED_LAST, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                                  16'hFFFF, 16'hFFFF));
        send_request(make_request(REQ_SET, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000));
    endtask

    // commands while idle, ticks while busy, some noise on top
    task automatic run_random();
        t_in_req     r;
        int unsigned n;
        int unsigned pick;
        int unsigned breathe_runs;
        breathe_runs = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            r    = random_fields();
            pick = $urandom_range(0, 99);
            if (led_sb.is_busy()) begin
                if (pick < 5)
                    r.req_type = 3'($urandom_range(REQ_SET, REQ_BREATHE));
                else if (pick < 8)
                    r.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
                else
                    r.req_type = REQ_TICK;
            end else if (pick < 6) begin
                r.req_type = REQ_TICK;
            end else if (pick < 10) begin
                r.req_type = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            end else if (pick < 35) begin
                r.req_type = REQ_SET;
            end else if (pick < 65) begin
                r.req_type = REQ_FADE;
                case ($urandom_range(0, 7))
                    0:       r.time_length = '0;
                    1:       r.time_length = 16'($urandom_range(13, 300));
                    default: r.time_length = 16'($urandom_range(1, 12));
                endcase
            end else if (pick < 92) begin
                r.req_type = REQ_BLINK;
                case ($urandom_range(0, 3))
                    0: r.repeat_count = '0;
                    1: r.time_length  = '0;
                    default: begin
                        r.time_length  = 16'($urandom_range(1, 4));
                        r.repeat_count = 16'($urandom_range(1, 4));
                    end
                endcase
            end else begin
                r.req_type = REQ_BREATHE;
                case ($urandom_range(0, 2))
                    0: r.repeat_count = '0;
                    1: r.time_length  = 16'($urandom_range(0, 2 * BREATHE_STEPS - 1));
                    default: begin
                        // a full breathe is long, so only one runs and it wraps once
                        if (breathe_runs < MAX_BREATHE_RUNS) begin
                            r.time_length  = 16'($urandom_range(2 * BREATHE_STEPS,
                                                                 4 * BREATHE_STEPS - 1));
                            r.repeat_count = 16'd2;
                            breathe_runs++;
                        end else begin
                            r.repeat_count = '0;
                        end
                    end
                endcase
            end
            send_request(r);
        end
    endtask

    // result side: random stalls, one long hold-off to back up the input
    initial begin : result_sink
        int unsigned hold_off;
        bit          sink_quiet;
        bit          long_done;
        sink_quiet = 1'b0;
        long_done  = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
            if (!long_done && led_sb.n_checked >= LONG_HOLD_AT) begin
                hold_off  = LONG_HOLD_CYCLES;
                long_done = 1'b1;
            end else begin
                hold_off = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_off != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            led_sb.check_result(o_out_res);
        end
    end

    // main sequence
    initial begin : stimulus
        led_sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("requests: %0d ticks, %0d set, %0d fade, %0d blink, %0d breathe, %0d unused",
                 led_sb.n_cmd[REQ_TICK], led_sb.n_cmd[REQ_SET], led_sb.n_cmd[REQ_FADE],
                 led_sb.n_cmd[REQ_BLINK], led_sb.n_cmd[REQ_BREATHE], led_sb.n_unused);
        $display("%0d results checked, %0d commands refused while busy, %0d mismatches",
                 led_sb.n_checked, led_sb.n_rejected, led_sb.n_mismatch);
        if (led_sb.n_mismatch == 0 && led_sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
